/* rtl/sdt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdt_pkg
// Shared types for the squared distance transform block.
// ----------------------------------------------------------------------------
package sdt_pkg;

    typedef enum logic [0:0] {
        REG_TRACK_ORIGIN = 1'b0
    } t_reg_index;

    localparam logic [31:0] OUT_MAX = 32'hFFFF_FFFF;

endpackage

/* rtl/sdt_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdt_front
// Accepts sample beats, stamps each with its position, and marks the beat
// that ends the line. Stamped beats go into a small queue.
// ----------------------------------------------------------------------------
module sdt_front #(
    parameter int MAX_LEN  = 64,
    parameter int POS_BITS = 6,
    parameter int QDEPTH   = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [31:0]         i_cost,
    input  logic [31:0]         i_label,
    input  logic                i_last,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [31:0]         o_cost,
    output logic [31:0]         o_label,
    output logic [POS_BITS-1:0] o_pos,
    output logic                o_end
);
    localparam int QB = $clog2(QDEPTH);
    localparam int W  = 32 + 32 + POS_BITS + 1;

    logic [W-1:0]       r_q [QDEPTH];
    logic [QB-1:0]      r_wp, r_rp;
    logic [QB:0]        r_cnt;
    logic [POS_BITS-1:0] r_pos;
    logic               push, pop, is_end;

    assign o_ready = (r_cnt != (QB+1)'(QDEPTH));
    assign push    = i_valid && o_ready;
    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_ready;
    assign is_end  = i_last || (r_pos == POS_BITS'(MAX_LEN - 1));
    assign {o_cost, o_label, o_pos, o_end} = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_pos <= '0;
        end else begin
            if (push) begin
                r_q[r_wp] <= {i_cost, i_label, r_pos, is_end};
                r_wp      <= (r_wp == QB'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
                r_pos     <= is_end ? '0 : r_pos + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == QB'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QB+1)'(push) - (QB+1)'(pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && !pop && r_cnt == (QB+1)'(QDEPTH))) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && r_cnt == '0)) else $error("queue underflow");
    a_pos_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && is_end |=> r_pos == '0) else $error("position not reset at line end");
`endif
endmodule

/* rtl/sdt_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdt_back
// Stores the line, builds the lower envelope of parabolas with exact
// fraction boundaries, and reads out one result beat per position.
// ----------------------------------------------------------------------------
module sdt_back #(
    parameter int MAX_LEN     = 64,
    parameter int SAMPLE_BITS = 32,
    parameter int POS_BITS    = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_track,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [31:0]         i_cost,
    input  logic [31:0]         i_label,
    input  logic [POS_BITS-1:0] i_pos,
    input  logic                i_end,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [31:0]         o_dist,
    output logic [31:0]         o_label,
    output logic                o_last
);
    localparam int SB = SAMPLE_BITS;
    localparam int FB = SB + 2 * POS_BITS + 1;
    localparam int NB = FB + 1;
    localparam int DB = POS_BITS + 2;
    localparam int PB = NB + DB;
    localparam int CB = POS_BITS + 1;
    localparam logic [SB:0] LIMIT = (SB < 32) ? {1'b0, {SB{1'b1}}} : (SB+1)'(32'hFFFF_FFFF);

    typedef enum logic [3:0] {
        S_LOAD, S_B_RD, S_B_CALC, S_B_MUL, S_B_DEC,
        S_R_RD, S_R_CMP, S_R_SEL, S_R_RD2, S_R_OUT
    } t_state;

    logic [SB-1:0]      r_samp [MAX_LEN];
    logic [31:0]        r_lab  [MAX_LEN];
    logic [POS_BITS-1:0] r_env [MAX_LEN];
    logic signed [NB-1:0] r_bnum [MAX_LEN];
    logic [DB-1:0]      r_bden [MAX_LEN];

    t_state              r_st;
    logic [CB-1:0]       r_n;
    logic [POS_BITS-1:0] r_q, r_top, r_k, r_p;
    logic [SB-1:0]       r_fp, r_fq;
    logic signed [NB-1:0] r_num, r_tnum;
    logic [DB-1:0]       r_den, r_tden;
    logic signed [PB-1:0] r_lhs, r_rhs;
    logic [31:0]         r_plab;
    logic [31:0]         r_odist, r_olab;
    logic                r_ovalid, r_olast;

    logic [FB-1:0] fq_full, fp_full;
    logic [2*POS_BITS-1:0] qq, pp, dd;
    logic [POS_BITS-1:0] dabs;
    logic [SB:0] dist_sum;

    assign o_ready = (r_st == S_LOAD);
    assign o_valid = r_ovalid;
    assign o_dist  = r_odist;
    assign o_label = r_olab;
    assign o_last  = r_olast;

    assign qq = r_q * r_q;
    assign pp = r_p * r_p;
    assign fq_full = FB'(r_fq) + FB'(qq);
    assign fp_full = FB'(r_fp) + FB'(pp);
    assign dabs = (r_q > r_p) ? r_q - r_p : r_p - r_q;
    assign dd = dabs * dabs;
    assign dist_sum = (SB+1)'(r_fp) + (SB+1)'(dd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_LOAD;
            r_ovalid <= 1'b0;
            r_top    <= '0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_st)
                S_LOAD: begin
                    if (i_valid) begin
                        r_samp[i_pos] <= SB'(i_cost);
                        r_lab[i_pos]  <= i_label;
                        if (i_end) begin
                            r_n     <= CB'(i_pos) + 1'b1;
                            r_env[0] <= '0;
                            r_bnum[0] <= '0;
                            r_bden[0] <= DB'(1);
                            r_top   <= '0;
                            r_q     <= POS_BITS'(1);
                            r_st    <= (i_pos == '0) ? S_R_RD : S_B_RD;
                            r_k     <= '0;
                            if (i_pos == '0) r_q <= '0;
                        end
                    end
                end
                S_B_RD: begin
                    r_p    <= r_env[r_top];
                    r_fq   <= r_samp[r_q];
                    r_tnum <= r_bnum[r_top];
                    r_tden <= r_bden[r_top];
                    r_st   <= S_B_CALC;
                end
                S_B_CALC: begin
                    r_fp <= r_samp[r_p];
                    r_st <= S_B_MUL;
                end
                S_B_MUL: begin
                    r_num <= NB'(fq_full) - NB'(fp_full);
                    r_den <= DB'({1'b0, r_q - r_p, 1'b0});
                    r_st  <= S_B_DEC;
                end
                S_B_DEC: begin
                    if (r_top != '0 && !((PB'(r_num) * $signed({1'b0, r_tden}))
                                         > (PB'(r_tnum) * $signed({1'b0, r_den})))) begin
                        r_top <= r_top - 1'b1;
                        r_st  <= S_B_RD;
                    end else begin
                        r_top <= r_top + 1'b1;
                        r_env[r_top + 1'b1]  <= r_q;
                        r_bnum[r_top + 1'b1] <= r_num;
                        r_bden[r_top + 1'b1] <= r_den;
                        if (CB'(r_q) + 1'b1 == r_n) begin
                            r_q  <= '0;
                            r_k  <= '0;
                            r_st <= S_R_RD;
                        end else begin
                            r_q  <= r_q + 1'b1;
                            r_st <= S_B_RD;
                        end
                    end
                end
                S_R_RD: begin
                    r_tnum <= r_bnum[r_k + 1'b1];
                    r_tden <= r_bden[r_k + 1'b1];
                    r_st   <= S_R_CMP;
                end
                S_R_CMP: begin
                    r_lhs <= PB'(r_tnum);
                    r_rhs <= $signed(PB'({1'b0, r_q})) * $signed({1'b0, r_tden});
                    r_st  <= S_R_SEL;
                end
                S_R_SEL: begin
                    if (r_k < r_top && r_lhs < r_rhs) begin
                        r_k  <= r_k + 1'b1;
                        r_st <= S_R_RD;
                    end else begin
                        r_p  <= r_env[r_k];
                        r_st <= S_R_RD2;
                    end
                end
                S_R_RD2: begin
                    r_fp   <= r_samp[r_p];
                    r_plab <= r_lab[r_p];
                    r_st   <= S_R_OUT;
                end
                S_R_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_odist  <= (dist_sum > LIMIT) ? 32'(LIMIT) : 32'(dist_sum);
                        r_olab   <= i_track ? r_plab : '0;
                        r_olast  <= (CB'(r_q) + 1'b1 == r_n);
                        if (CB'(r_q) + 1'b1 == r_n) begin
                            r_st <= S_LOAD;
                        end else begin
                            r_q  <= r_q + 1'b1;
                            r_st <= S_R_RD;
                        end
                    end
                end
                default: r_st <= S_LOAD;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !i_ready |=> r_ovalid && $stable(r_odist)) else $error("result dropped");
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_R_SEL |-> r_k <= r_top) else $error("envelope index past top");
    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_B_DEC |-> r_den != '0) else $error("zero denominator");
`endif
endmodule

/* rtl/squared_distance_transform_1d.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// squared_distance_transform_1d
// One-dimensional squared distance transform over a line of cost samples.
// ----------------------------------------------------------------------------
// Sample beats are taken into a four-entry queue at one per cycle while it has
// room, and stored by the back end at one per cycle while it is loading. The
// beat flagged last, or the one filling position MAX_LEN-1, ends the line. The
// envelope build then runs each envelope test as a memory read, an operand read,
// a subtract and a cross-multiply compare, and readout steps through the
// boundaries (read, multiply, compare) before reading the chosen sample and
// emitting each result. The back end takes no samples while a line is being
// processed, so the queue fills and then holds off the input.
module squared_distance_transform_1d #(
    parameter int MAX_LEN     = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_cost_sample,
    input  logic [31:0] i_origin_label,
    input  logic        i_line_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_distance_value,
    output logic [31:0] o_nearest_label,
    output logic        o_result_last
);
    localparam int POS_BITS = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;

    logic                r_track;
    logic                q_valid, q_ready, q_end;
    logic [31:0]         q_cost, q_label;
    logic [POS_BITS-1:0] q_pos;

    assign pready = 1'b1;
    assign prdata = (paddr == 1'(sdt_pkg::REG_TRACK_ORIGIN)) ? {31'b0, r_track} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track <= 1'b1;
        end else if (psel && penable && pwrite
                     && paddr == 1'(sdt_pkg::REG_TRACK_ORIGIN)) begin
            r_track <= pwdata[0];
        end
    end

    sdt_front #(.MAX_LEN(MAX_LEN), .POS_BITS(POS_BITS), .QDEPTH(4)) u_front (
        .i_clk, .i_rst_n,
        .i_valid, .o_ready,
        .i_cost(i_cost_sample), .i_label(i_origin_label), .i_last(i_line_last),
        .o_valid(q_valid), .i_ready(q_ready),
        .o_cost(q_cost), .o_label(q_label), .o_pos(q_pos), .o_end(q_end)
    );

    sdt_back #(.MAX_LEN(MAX_LEN), .SAMPLE_BITS(SAMPLE_BITS), .POS_BITS(POS_BITS)) u_back (
        .i_clk, .i_rst_n, .i_track(r_track),
        .i_valid(q_valid), .o_ready(q_ready),
        .i_cost(q_cost), .i_label(q_label), .i_pos(q_pos), .i_end(q_end),
        .o_valid, .i_ready,
        .o_dist(o_distance_value), .o_label(o_nearest_label), .o_last(o_result_last)
    );
endmodule

/* tb/sv/sdt_distance_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdt_distance_checker
// Watches the sample, result and register ports of the distance transform,
// rebuilds each line, computes the lower envelope of parabolas itself and
// compares every result beat field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module sdt_distance_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [31:0] i_cost_sample,
    input  logic [31:0] i_origin_label,
    input  logic        i_line_last,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [31:0] o_distance_value,
    input  logic [31:0] o_nearest_label,
    input  logic        o_result_last,
    output int          o_fail_count,
    output int          o_pending
);
    localparam int LINE_MAX = 64;

    typedef struct {
        logic [31:0] dist_value;
        logic [31:0] label;
        logic        last;
    } t_distance_beat;

    t_distance_beat expected_results[$];
    logic [31:0]    line_cost[LINE_MAX];
    logic [31:0]    line_label[LINE_MAX];
    int             line_fill;
    logic           track_label;

    function automatic void predict_line(input int n);
        int              hull_idx[LINE_MAX];
        longint          edge_num[LINE_MAX + 1];
        longint          edge_den[LINE_MAX + 1];
        int              top;
        int              k;
        int              p;
        longint          num;
        longint          den;
        longint          fq;
        longint unsigned d;
        longint unsigned total;
        t_distance_beat  beat;
        top = 0;
        hull_idx[0] = 0;
        edge_num[0] = 0;
        edge_den[0] = 1;
        for (int q = 1; q < n; q++) begin
            fq = longint'(line_cost[q]) + longint'(q) * q;
            forever begin
                p = hull_idx[top];
                num = fq - (longint'(line_cost[p]) + longint'(p) * p);
                den = 2 * (q - p);
                if (top == 0) break;
                if (num * edge_den[top] > edge_num[top] * den) break;
                top--;
            end
            top++;
            hull_idx[top] = q;
            edge_num[top] = num;
            edge_den[top] = den;
        end
        k = 0;
        for (int q = 0; q < n; q++) begin
            while (k < top && edge_num[k + 1] < longint'(q) * edge_den[k + 1]) k++;
            p = hull_idx[k];
            d = (q > p) ? longint'(q - p) : longint'(p - q);
            total = d * d + longint'(line_cost[p]);
            if (total > longint'(sdt_pkg::OUT_MAX)) total = longint'(sdt_pkg::OUT_MAX);
            beat.dist_value = total[31:0];
            beat.label = track_label ? line_label[p] : 32'd0;
            beat.last = (q + 1 == n);
            expected_results.push_back(beat);
        end
    endfunction

    always @(posedge i_clk) begin
        t_distance_beat want;
        if (!i_rst_n) begin
            line_fill = 0;
            track_label = 1'b1;
            o_fail_count = 0;
            expected_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) track_label = pwdata[0];
            if (i_valid && o_ready) begin
                line_cost[line_fill] = i_cost_sample;
                line_label[line_fill] = i_origin_label;
                line_fill++;
                if (i_line_last || line_fill == LINE_MAX) begin
                    predict_line(line_fill);
                    line_fill = 0;
                end
            end
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("Unexpected result beat: dist %h label %h last %b",
                                 o_distance_value, o_nearest_label, o_result_last);
                end else begin
                    want = expected_results.pop_front();
                    if (want.dist_value !== o_distance_value
                        || want.label !== o_nearest_label
                        || want.last !== o_result_last) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("Mismatch: expected %h %h %b, got %h %h %b",
                                     want.dist_value, want.label, want.last,
                                     o_distance_value, o_nearest_label, o_result_last);
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives cost lines of varied length and content into the distance transform
// through several idle and stall phases and register settings, and reports
// the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_top;
    localparam int CYCLE_LIMIT = 1000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_cost_sample;
    logic [31:0] i_origin_label;
    logic        i_line_last;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_distance_value;
    logic [31:0] o_nearest_label;
    logic        o_result_last;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_stall_pct;
    logic        hold_armed;
    int          beats_sent;
    int          cycle_count;

    squared_distance_transform_1d u_top (.*);

    sdt_distance_checker u_checker (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .pwdata, .pready,
        .i_valid, .o_ready, .i_cost_sample, .i_origin_label, .i_line_last,
        .o_valid, .i_ready, .o_distance_value, .o_nearest_label, .o_result_last,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        int hold_left;
        logic held;
        hold_left = 0;
        held = 1'b0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_armed && !held) begin
                held = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready = 1'b0;
            end else begin
                i_ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic put_beat(input logic [31:0] cost, input logic [31:0] label,
                            input logic last);
        @(negedge i_clk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_cost_sample = cost;
        i_origin_label = label;
        i_line_last = last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        beats_sent++;
    endtask

    function automatic logic [31:0] pick_cost(input int flavor);
        case (flavor)
            0: return $urandom_range(200);
            1: return 32'hFFFF_FF00 | $urandom_range(255);
            2: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_line(input int len, input logic mark_last);
        int flavor;
        flavor = $urandom_range(4);
        for (int i = 0; i < len; i++)
            put_beat(($urandom_range(3) == 0) ? pick_cost($urandom_range(3))
                                              : pick_cost(flavor),
                     $urandom, mark_last && (i == len - 1));
    endtask

    task automatic drain_and_pause();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_track(input logic value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = sdt_pkg::REG_TRACK_ORIGIN;
        pwdata = {31'd0, value};
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic random_phase(input int idle_pct, input int stall_pct, input int quota);
        int goal;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        goal = beats_sent + quota;
        while (beats_sent < goal) begin
            if ($urandom_range(19) == 0)
                send_line(64, $urandom_range(1));
            else
                send_line($urandom_range(1, 10), 1'b1);
        end
        drain_and_pause();
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_valid = 1'b0;
        i_cost_sample = '0;
        i_origin_label = '0;
        i_line_last = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_armed = 1'b0;
        beats_sent = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        put_beat(32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
        put_beat(32'd0, 32'h7FFF_FFFF, 1'b1);
        put_beat(32'd5, 32'd1, 1'b0);
        put_beat(32'd5, 32'd2, 1'b0);
        put_beat(32'd5, 32'd3, 1'b1);
        put_beat(32'd4, 32'hFFFF_FFFF, 1'b0);
        put_beat(32'd0, 32'd0, 1'b0);
        put_beat(32'd4, 32'd9, 1'b1);
        put_beat(32'hFFFF_FFF0, 32'd11, 1'b0);
        put_beat(32'hFFFF_FFFF, 32'd12, 1'b0);
        put_beat(32'hFFFF_FFFF, 32'd13, 1'b0);
        put_beat(32'hFFFF_FFFF, 32'd14, 1'b1);
        for (int i = 0; i < 6; i++) put_beat(32'd100 - 20 * i, i, i == 5);
        put_beat(32'd1, 32'hAAAA_AAAA, 1'b0);
        put_beat(32'd0, 32'h5555_5555, 1'b1);
        drain_and_pause();

        write_track(1'b0);
        random_phase(0, 0, 60);
        write_track(1'b1);
        random_phase(47, 0, 60);
        write_track(1'b0);
        hold_armed = 1'b1;
        random_phase(0, 47, 60);
        write_track(1'b1);
        random_phase(32, 32, 60);

        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
